>>> hdl/assert_macros.svh
// Assertion macros for the checkers; clk and arst_n must be in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

>>> hdl/rlnrz_pkg.sv
package rlnrz_pkg;

	localparam int DURATION_BITS_DEF = 15;
	localparam int PERIOD_W = 15;
	localparam int CLOCK_HZ = 40000000;
	localparam int BIT_RATE = 40000;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(CLOCK_HZ / BIT_RATE);
	localparam int BYTE_W = 8;
	localparam int NBITS_W = 4;
	localparam logic [2:0] LAST_BIT = 3'd7;
	localparam logic [NBITS_W-1:0] FULL_BITS = 4'd8;
	localparam int MAX_RESULTS = 64;
	localparam int OUT_DATA_W = ((BYTE_W + NBITS_W + 7) / 8) * 8;

	typedef struct packed {
		logic [BYTE_W-1:0]  data;
		logic [NBITS_W-1:0] nbits;
	} res_t;

endpackage

>>> hdl/run_length_nrz_byte_decoder.sv
// Channel   | Handshake           | Payload
// s_axis    | tvalid / tready     | tdata: symbol pair, tuser: burst start, tlast: burst end
// m_axis    | tvalid / tready     | tdata: byte and bit count, tlast: last result of item
// cfg       | valid / ready       | data: bit period in ticks
// An item is accepted, each half's duration goes through the shared restoring divider, the
// quotient's bits are shifted into the byte, and the item ends with a flush and a close;
// a burst-start item goes straight to the flush and the close. Output back-pressure stalls the
// shifter, the flush and the close while the hold and output registers are both full.
// Reset loads the bit period with 1000 and empties the byte assembler and output stage.
module run_length_nrz_byte_decoder #(
	parameter int DURATION_BITS = rlnrz_pkg::DURATION_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// first_level, first_duration, second_level, second_duration, zero fill
	input  logic [((2*DURATION_BITS+2+7)/8)*8-1:0] s_axis_tdata,
	// burst_start
	input  logic                                   s_axis_tuser,
	input  logic                                   s_axis_tlast,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// data_byte, valid_bits, zero fill
	output logic [rlnrz_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
	output logic                                   m_axis_tlast,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [rlnrz_pkg::PERIOD_W-1:0]         cfg_data
);

	localparam int D = DURATION_BITS;

	typedef enum logic [2:0] {
		S_IDLE, S_DIV0, S_RUN0, S_DIV1, S_RUN1, S_FLUSH, S_CLOSE
	} state_t;

	state_t                         state_q;
	logic [rlnrz_pkg::BYTE_W-1:0]   cnt_q;
	logic                           lvl0_q;
	logic                           lvl1_q;
	logic [D-1:0]                   dur1_q;
	logic                           end_q;
	logic [rlnrz_pkg::PERIOD_W-1:0] period_q;

	logic                           s_accept;
	logic                           running;
	logic                           cur_level;
	logic                           shift_want;
	logic                           flush_want;
	logic                           push;
	rlnrz_pkg::res_t                push_res;
	rlnrz_pkg::res_t                shift_res;
	rlnrz_pkg::res_t                flush_res;
	logic                           at_last;
	logic                           pending;
	logic                           step_ok;
	logic                           close_ok;
	logic                           shift_en;
	logic                           flush_en;
	logic                           div_start;
	logic [D-1:0]                   div_dvd;
	logic                           div_done;
	logic [rlnrz_pkg::BYTE_W-1:0]   div_quot;
	logic [rlnrz_pkg::BYTE_W-1:0]   run_len;

	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign s_accept = s_axis_tvalid & s_axis_tready;

	assign running = (state_q == S_RUN0) | (state_q == S_RUN1);
	assign cur_level = (state_q == S_RUN0) ? lvl0_q : lvl1_q;
	assign shift_want = running & (cnt_q != '0);
	assign flush_want = (state_q == S_FLUSH) & end_q & pending;
	assign push = (shift_want & at_last) | flush_want;
	assign push_res = (state_q == S_FLUSH) ? flush_res : shift_res;
	assign shift_en = shift_want & step_ok;
	assign flush_en = flush_want & step_ok;

	assign div_start = (s_accept & ~s_axis_tuser) | ((state_q == S_RUN0) & (cnt_q == '0));
	assign div_dvd = (state_q == S_IDLE) ? s_axis_tdata[D:1] : dur1_q;
	assign run_len = (period_q == '0) ? '0 : div_quot;

	rlnrz_div #(
		.DVD_W(D)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (period_q),
		.done     (div_done),
		.quot     (div_quot)
	);

	rlnrz_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.shift_en  (shift_en),
		.flush_en  (flush_en),
		.level     (cur_level),
		.shift_res (shift_res),
		.flush_res (flush_res),
		.at_last   (at_last),
		.pending   (pending)
	);

	rlnrz_outq u_outq (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.push_res      (push_res),
		.close         (state_q == S_CLOSE),
		.step_ok       (step_ok),
		.close_ok      (close_ok),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			lvl0_q <= 1'b0;
			lvl1_q <= 1'b0;
			dur1_q <= '0;
			end_q <= 1'b0;
			period_q <= rlnrz_pkg::PERIOD_RESET;
		end else begin
			if (cfg_valid)
				period_q <= cfg_data;
			unique case (state_q)
				S_IDLE: begin
					if (s_accept) begin
						lvl0_q <= s_axis_tdata[0];
						lvl1_q <= s_axis_tdata[D+1];
						dur1_q <= s_axis_tdata[2*D+1:D+2];
						end_q <= s_axis_tlast;
						state_q <= s_axis_tuser ? S_FLUSH : S_DIV0;
					end
				end
				S_DIV0: begin
					if (div_done) begin
						cnt_q <= run_len;
						state_q <= S_RUN0;
					end
				end
				S_RUN0: begin
					if (cnt_q == '0)
						state_q <= S_DIV1;
					else if (step_ok)
						cnt_q <= cnt_q - 1'b1;
				end
				S_DIV1: begin
					if (div_done) begin
						cnt_q <= run_len;
						state_q <= S_RUN1;
					end
				end
				S_RUN1: begin
					if (cnt_q == '0)
						state_q <= S_FLUSH;
					else if (step_ok)
						cnt_q <= cnt_q - 1'b1;
				end
				S_FLUSH: begin
					if (~flush_want | step_ok)
						state_q <= S_CLOSE;
				end
				S_CLOSE: begin
					if (close_ok)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> hdl/rlnrz_div.sv
module rlnrz_div #(
	parameter int DVD_W = rlnrz_pkg::DURATION_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [DVD_W-1:0]              dividend,
	input  logic [rlnrz_pkg::PERIOD_W-1:0] divisor,
	output logic                          done,
	output logic [rlnrz_pkg::BYTE_W-1:0]  quot
);

	localparam int PW = rlnrz_pkg::PERIOD_W;
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0]              dvd_q;
	logic [PW-1:0]                 rem_q;
	logic [rlnrz_pkg::BYTE_W-1:0]  quot_q;
	logic [CNT_W-1:0]              cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [PW:0]                   rem_sh;
	logic [PW+1:0]                 diff;
	logic                          ge;

	assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
	assign diff = {1'b0, rem_sh} - {2'b00, divisor};
	assign ge = ~diff[PW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= ge ? diff[PW-1:0] : rem_sh[PW-1:0];
			quot_q <= {quot_q[rlnrz_pkg::BYTE_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

>>> hdl/rlnrz_pack.sv
module rlnrz_pack (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift_en,
	input  logic             flush_en,
	input  logic             level,
	output rlnrz_pkg::res_t  shift_res,
	output rlnrz_pkg::res_t  flush_res,
	output logic             at_last,
	output logic             pending
);

	logic [2:0]                    pos_q;
	logic [rlnrz_pkg::BYTE_W-1:0]  byte_q;

	assign at_last = (pos_q == 3'd0);
	assign pending = (pos_q != rlnrz_pkg::LAST_BIT);

	assign shift_res.data = byte_q | {{(rlnrz_pkg::BYTE_W-1){1'b0}}, level};
	assign shift_res.nbits = rlnrz_pkg::FULL_BITS;
	assign flush_res.data = byte_q;
	assign flush_res.nbits = {1'b0, rlnrz_pkg::LAST_BIT - pos_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= rlnrz_pkg::LAST_BIT;
			byte_q <= '0;
		end else if (shift_en) begin
			if (at_last) begin
				pos_q <= rlnrz_pkg::LAST_BIT;
				byte_q <= '0;
			end else begin
				pos_q <= pos_q - 1'b1;
				byte_q <= byte_q | (rlnrz_pkg::BYTE_W'(level) << pos_q);
			end
		end else if (flush_en) begin
			pos_q <= rlnrz_pkg::LAST_BIT;
			byte_q <= '0;
		end
	end

endmodule

>>> hdl/rlnrz_outq.sv
module rlnrz_outq (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  rlnrz_pkg::res_t                     push_res,
	input  logic                                close,
	output logic                                step_ok,
	output logic                                close_ok,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [rlnrz_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	output logic                                m_axis_tlast
);

	localparam int CNT_W = $clog2(rlnrz_pkg::MAX_RESULTS + 1);
	localparam int PAD_W = rlnrz_pkg::OUT_DATA_W - rlnrz_pkg::BYTE_W - rlnrz_pkg::NBITS_W;

	rlnrz_pkg::res_t  hold_q;
	rlnrz_pkg::res_t  out_q;
	logic             hold_v_q;
	logic             out_v_q;
	logic             out_last_q;
	logic [CNT_W-1:0] cnt_q;
	logic             drop;
	logic             out_free;
	logic             room;
	logic             push_acc;
	logic             close_acc;
	logic             move;

	assign drop = (cnt_q == CNT_W'(rlnrz_pkg::MAX_RESULTS));
	assign out_free = ~out_v_q | m_axis_tready;
	assign room = ~hold_v_q | out_free;
	assign step_ok = ~push | drop | room;
	assign close_ok = ~hold_v_q | out_free;
	assign push_acc = push & ~drop & room;
	assign close_acc = close & close_ok;
	assign move = hold_v_q & (push_acc | close_acc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			out_v_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (move)
				out_v_q <= 1'b1;
			else if (m_axis_tready)
				out_v_q <= 1'b0;
			if (push_acc) begin
				hold_v_q <= 1'b1;
				cnt_q <= cnt_q + 1'b1;
			end else if (close_acc) begin
				hold_v_q <= 1'b0;
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_acc)
			hold_q <= push_res;
		if (move) begin
			out_q <= hold_q;
			out_last_q <= close_acc;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = {{PAD_W{1'b0}}, out_q.nbits, out_q.data};
	assign m_axis_tlast = out_last_q;

endmodule

>>> hdl/rlnrz_chk.sv
`include "assert_macros.svh"

module rlnrz_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tvalid,
	input logic                              s_axis_tready,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [rlnrz_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input logic                              m_axis_tlast
);

	localparam int NB_LO = rlnrz_pkg::BYTE_W;
	localparam int NB_HI = rlnrz_pkg::BYTE_W + rlnrz_pkg::NBITS_W - 1;

	logic                             out_stall;
	logic [rlnrz_pkg::OUT_DATA_W:0]   out_word;
	logic [rlnrz_pkg::NBITS_W-1:0]    nbits;

	assign out_stall = m_axis_tvalid && !m_axis_tready;
	assign out_word = {m_axis_tlast, m_axis_tdata};
	assign nbits = m_axis_tdata[NB_HI:NB_LO];

	// hold the output while stalled
	`ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_word))
	// bit count stays within one byte
	`ASSERT_NOW(a_nbits_range, m_axis_tvalid, nbits != '0 && nbits <= rlnrz_pkg::FULL_BITS)
	// a partial byte only closes an item
	`ASSERT_NOW(a_partial_last, m_axis_tvalid && nbits != rlnrz_pkg::FULL_BITS, m_axis_tlast)
	// drop ready after each input transfer
	`ASSERT_NEXT(a_busy_after_in, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind run_length_nrz_byte_decoder rlnrz_chk u_rlnrz_chk (.*);

>>> sim/tb_run_length_nrz_byte_decoder.sv
module tb_run_length_nrz_byte_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PERIOD_W = rlnrz_pkg::PERIOD_W;
	localparam int BYTE_W = rlnrz_pkg::BYTE_W;
	localparam int NBITS_W = rlnrz_pkg::NBITS_W;
	localparam int OUT_DATA_W = rlnrz_pkg::OUT_DATA_W;
	localparam int MAX_RESULTS = rlnrz_pkg::MAX_RESULTS;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = rlnrz_pkg::PERIOD_RESET;
	localparam logic [2:0] LAST_BIT = rlnrz_pkg::LAST_BIT;
	localparam logic [NBITS_W-1:0] FULL_BITS = rlnrz_pkg::FULL_BITS;

	localparam int DUR_W = rlnrz_pkg::DURATION_BITS_DEF;
	localparam int SYM_W = ((2 * DUR_W + 2 + 7) / 8) * 8;
	localparam int HALF_PERIOD = 4;
	localparam int RESET_CYCLES = 7;
	localparam int IDLE_PCT = 12;
	localparam int SETTLE_CYCLES = 100;
	localparam int HOLD_CYCLES = 600;
	localparam int PHASES = 4;
	localparam int PHASE_SYMBOLS = 30;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int MAX_REPORTS = 40;
	localparam int N_DIRECTED = 21;
	localparam logic [DUR_W-1:0] DUR_MAX = '1;

	typedef enum logic {ROW_ITEM, ROW_PERIOD} row_kind_t;

	typedef struct packed {
		logic             first_level;
		logic [DUR_W-1:0] first_duration;
		logic             second_level;
		logic [DUR_W-1:0] second_duration;
		logic             burst_start;
		logic             burst_end;
	} symbol_t;

	typedef struct packed {
		row_kind_t           kind;
		logic [PERIOD_W-1:0] period;
		symbol_t             sym;
		logic                typed;
		logic                has_byte;
		logic [BYTE_W-1:0]   exp_data;
		logic [NBITS_W-1:0]  exp_bits;
	} dir_row_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  data;
		logic [NBITS_W-1:0] nbits;
		logic               run_last;
	} rx_byte_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [SYM_W-1:0]      s_axis_tdata = '0;
	logic                  s_axis_tuser = 1'b0;
	logic                  s_axis_tlast = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [PERIOD_W-1:0]   cfg_data = '0;

	logic                  hold_req = 1'b0;
	logic                  steady = 1'b0;
	int                    hold_count = 0;

	logic [PERIOD_W-1:0]   bit_period = PERIOD_RESET;
	logic [2:0]            bit_pos = LAST_BIT;
	logic [BYTE_W-1:0]     partial = '0;
	rx_byte_t              expected_bytes[$];

	int                    mismatches = 0;
	int                    symbols_sent = 0;
	int                    directed_count = 0;
	int                    periods_written = 0;
	int                    full_bytes = 0;
	int                    partial_bytes = 0;
	int                    cycle_count = 0;

	dir_row_t directed_rows [N_DIRECTED] = '{
		'{ROW_ITEM, 15'd0, '{1'b1, 15'd8000, 1'b0, 15'd0, 1'b0, 1'b0},
			1'b1, 1'b1, 8'hFF, 4'd8},
		'{ROW_ITEM, 15'd0, '{1'b0, 15'd8999, 1'b1, 15'd999, 1'b0, 1'b0},
			1'b1, 1'b1, 8'h00, 4'd8},
		'{ROW_ITEM, 15'd0, '{1'b1, 15'd32767, 1'b1, 15'd32767, 1'b1, 1'b0},
			1'b1, 1'b0, 8'h00, 4'd0},
		'{ROW_ITEM, 15'd0, '{1'b1, 15'd3000, 1'b0, 15'd2000, 1'b0, 1'b1},
			1'b1, 1'b1, 8'hE0, 4'd5},
		'{ROW_ITEM, 15'd0, '{1'b0, 15'd0, 1'b0, 15'd0, 1'b0, 1'b1},
			1'b1, 1'b0, 8'h00, 4'd0},
		'{ROW_ITEM, 15'd0, '{1'b1, 15'd1000, 1'b0, 15'd0, 1'b0, 1'b0},
			1'b1, 1'b0, 8'h00, 4'd0},
		'{ROW_ITEM, 15'd0, '{1'b1, 15'd5000, 1'b0, 15'd5000, 1'b1, 1'b1},
			1'b1, 1'b1, 8'h80, 4'd1},
		'{ROW_ITEM, 15'd0, '{1'b1, 15'd32767, 1'b1, 15'd32767, 1'b0, 1'b0},
			1'b0, 1'b0, 8'h00, 4'd0},
		'{ROW_ITEM, 15'd0, '{1'b0, 15'd32767, 1'b1, 15'd7000, 1'b0, 1'b1},
			1'b0, 1'b0, 8'h00, 4'd0},
		'{ROW_PERIOD, 15'd1, '0, 1'b0, 1'b0, 8'h00, 4'd0},
		'{ROW_ITEM, 15'd0, '{1'b1, 15'd7, 1'b0, 15'd0, 1'b0, 1'b0},
			1'b1, 1'b0, 8'h00, 4'd0},
		'{ROW_ITEM, 15'd0, '{1'b1, 15'd255, 1'b0, 15'd255, 1'b0, 1'b1},
			1'b0, 1'b0, 8'h00, 4'd0},
		'{ROW_ITEM, 15'd0, '{1'b1, 15'd256, 1'b1, 15'd32767, 1'b0, 1'b0},
			1'b0, 1'b0, 8'h00, 4'd0},
		'{ROW_ITEM, 15'd0, '{1'b0, 15'd0, 1'b0, 15'd0, 1'b0, 1'b1},
			1'b1, 1'b1, 8'hFE, 4'd7},
		'{ROW_PERIOD, 15'd32767, '0, 1'b0, 1'b0, 8'h00, 4'd0},
		'{ROW_ITEM, 15'd0, '{1'b1, 15'd32767, 1'b0, 15'd32766, 1'b0, 1'b1},
			1'b1, 1'b1, 8'h80, 4'd1},
		'{ROW_PERIOD, 15'd0, '0, 1'b0, 1'b0, 8'h00, 4'd0},
		'{ROW_ITEM, 15'd0, '{1'b1, 15'd32767, 1'b1, 15'd32767, 1'b0, 1'b1},
			1'b1, 1'b0, 8'h00, 4'd0},
		'{ROW_PERIOD, 15'd1000, '0, 1'b0, 1'b0, 8'h00, 4'd0},
		'{ROW_ITEM, 15'd0, '{1'b1, 15'd32767, 1'b1, 15'd32767, 1'b1, 1'b1},
			1'b1, 1'b0, 8'h00, 4'd0},
		'{ROW_ITEM, 15'd0, '{1'b0, 15'd2000, 1'b1, 15'd6000, 1'b0, 1'b0},
			1'b1, 1'b1, 8'h3F, 4'd8}
	};

	run_length_nrz_byte_decoder DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always begin
		clk = 1'b0;
		#HALF_PERIOD;
		clk = 1'b1;
		#HALF_PERIOD;
	end

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("mismatch at %0t ns: %s", $realtime, msg);
		end
	endtask

	function automatic void shift_level(input logic level, input logic [DUR_W-1:0] ticks,
			ref rx_byte_t bytes[$]);
		logic [7:0] count;
		count = (bit_period == '0) ? 8'd0 : 8'(ticks / bit_period);
		repeat (count) begin
			partial[bit_pos] = level;
			if (bit_pos == 3'd0) begin
				bytes.push_back('{partial, FULL_BITS, 1'b0});
				partial = '0;
				bit_pos = LAST_BIT;
			end else begin
				bit_pos = bit_pos - 3'd1;
			end
		end
	endfunction

	function automatic void decode_symbol(input symbol_t sym, ref rx_byte_t bytes[$]);
		if (!sym.burst_start) begin
			shift_level(sym.first_level, sym.first_duration, bytes);
			shift_level(sym.second_level, sym.second_duration, bytes);
		end
		if (sym.burst_end && bit_pos != LAST_BIT) begin
			bytes.push_back('{partial, NBITS_W'(LAST_BIT - bit_pos), 1'b0});
			partial = '0;
			bit_pos = LAST_BIT;
		end
		while (bytes.size() > MAX_RESULTS) begin
			void'(bytes.pop_back());
		end
		if (bytes.size() != 0) begin
			bytes[bytes.size() - 1].run_last = 1'b1;
		end
	endfunction

	function automatic logic [DUR_W-1:0] pick_duration();
		int unsigned ticks;
		if (bit_period == '0) begin
			return DUR_W'($urandom());
		end
		ticks = $urandom_range(9) * bit_period + $urandom_range(bit_period - 1);
		return (ticks > DUR_MAX) ? DUR_MAX : DUR_W'(ticks);
	endfunction

	function automatic symbol_t burst_symbol(input logic start, input logic last);
		symbol_t sym;
		sym.first_level = 1'($urandom_range(1));
		sym.first_duration = pick_duration();
		sym.second_level = 1'($urandom_range(1));
		sym.second_duration = pick_duration();
		sym.burst_start = start;
		sym.burst_end = last;
		return sym;
	endfunction

	function automatic symbol_t noise_symbol();
		symbol_t sym;
		sym.first_level = 1'($urandom_range(1));
		sym.first_duration = DUR_W'($urandom());
		sym.second_level = 1'($urandom_range(1));
		sym.second_duration = DUR_W'($urandom());
		sym.burst_start = 1'($urandom_range(1));
		sym.burst_end = 1'($urandom_range(1));
		return sym;
	endfunction

	task automatic send_symbol(input symbol_t sym, input logic typed, input logic has_byte,
			input logic [BYTE_W-1:0] exp_data, input logic [NBITS_W-1:0] exp_bits);
		rx_byte_t bytes[$];
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= SYM_W'({sym.second_duration, sym.second_level,
			sym.first_duration, sym.first_level});
		s_axis_tuser <= sym.burst_start;
		s_axis_tlast <= sym.burst_end;
		do @(posedge clk); while (!s_axis_tready);
		decode_symbol(sym, bytes);
		if (typed) begin
			bytes.delete();
			if (has_byte) begin
				bytes.push_back('{exp_data, exp_bits, 1'b1});
			end
		end
		foreach (bytes[k]) begin
			expected_bytes.push_back(bytes[k]);
		end
		symbols_sent++;
		@(negedge clk);
	endtask

	task automatic write_period(input logic [PERIOD_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		bit_period = value;
		periods_written++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic settle_block();
		s_axis_tvalid <= 1'b0;
		while (expected_bytes.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// hold off the output once for a long stretch, otherwise stall at random outside the steady phase
	always @(negedge clk) begin
		if (hold_req && hold_count < HOLD_CYCLES) begin
			m_axis_tready <= 1'b0;
			hold_count++;
		end else begin
			m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin : check_bytes
		rx_byte_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_bytes.size() == 0) begin
				note_mismatch($sformatf("unexpected byte %02h", m_axis_tdata[BYTE_W-1:0]));
			end else begin
				want = expected_bytes.pop_front();
				if (m_axis_tdata[BYTE_W-1:0] !== want.data) begin
					note_mismatch($sformatf("data_byte %02h, expected %02h",
						m_axis_tdata[BYTE_W-1:0], want.data));
				end
				if (m_axis_tdata[BYTE_W+NBITS_W-1:BYTE_W] !== want.nbits) begin
					note_mismatch($sformatf("valid_bits %0d, expected %0d",
						m_axis_tdata[BYTE_W+NBITS_W-1:BYTE_W], want.nbits));
				end
				if (m_axis_tlast !== want.run_last) begin
					note_mismatch($sformatf("run_last %b, expected %b",
						m_axis_tlast, want.run_last));
				end
				if (want.nbits == FULL_BITS) begin
					full_bytes++;
				end else begin
					partial_bytes++;
				end
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d bytes outstanding",
			cycle_count, expected_bytes.size());
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		symbol_t             sym;
		int                  counted;
		int                  nsym;
		logic [PERIOD_W-1:0] phase_period;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_PERIOD) begin
				settle_block();
				write_period(directed_rows[i].period);
			end else begin
				send_symbol(directed_rows[i].sym, directed_rows[i].typed,
					directed_rows[i].has_byte, directed_rows[i].exp_data,
					directed_rows[i].exp_bits);
			end
		end
		directed_count = symbols_sent;

		for (int phase = 0; phase < PHASES; phase++) begin
			settle_block();
			case (phase)
				0: begin
					phase_period = PERIOD_RESET;
				end
				1: begin
					phase_period = PERIOD_W'($urandom_range(40, 1));
				end
				2: begin
					phase_period = PERIOD_W'($urandom_range(5000, 100));
				end
				default: begin
					phase_period = PERIOD_W'($urandom_range(3000, 500));
				end
			endcase
			write_period(phase_period);
			hold_req <= (phase == 1);
			steady <= (phase == 2);
			counted = 0;
			while (counted < PHASE_SYMBOLS) begin
				if ($urandom_range(99) < 15) begin
					sym = noise_symbol();
					send_symbol(sym, 1'b0, 1'b0, '0, '0);
					if (!sym.burst_start || sym.burst_end) begin
						counted++;
					end
				end else begin
					send_symbol(burst_symbol(1'b1, 1'b0), 1'b0, 1'b0, '0, '0);
					nsym = $urandom_range(6, 1);
					for (int k = 1; k <= nsym; k++) begin
						send_symbol(burst_symbol(1'b0, k == nsym), 1'b0, 1'b0, '0, '0);
						counted++;
					end
				end
			end
		end
		settle_block();

		$display("Sent %0d symbols (%0d from the directed table) across %0d bit period writes;",
			symbols_sent, directed_count, periods_written);
		$display("compared %0d full and %0d flushed bytes, %0d mismatches.",
			full_bytes, partial_bytes, mismatches);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
